[rtl/hfws_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package hfws_pkg;

  localparam int COEF_W    = 16;
  localparam int FRAC_BITS = 14;

  typedef logic signed [COEF_W-1:0] coef_t;

  localparam coef_t COEF_RESET = 16'sd4096;

  // configuration register indexes
  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_COEF_PREV      = 2'd0;
  localparam reg_idx_t REG_COEF_CENTER    = 2'd1;
  localparam reg_idx_t REG_COEF_NEIGHBOUR = 2'd2;

  // request kinds
  typedef logic [1:0] req_t;
  localparam req_t REQ_STEP    = 2'd0;
  localparam req_t REQ_DISTURB = 2'd1;
  localparam req_t REQ_READ    = 2'd2;

  // result status
  localparam logic STATUS_DONE    = 1'b0;
  localparam logic STATUS_IGNORED = 1'b1;

  // one sweep position handed to the stencil pipe
  typedef struct packed {
    logic vld;
    logic interior;
  } stn_beat_t;

endpackage

`default_nettype wire

[rtl/hfws_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module hfws_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/hfws_stencil.sv]
`timescale 1ns / 1ps
`default_nettype none

module hfws_stencil #(
  parameter int GRID_COLS   = 128,
  parameter int HEIGHT_BITS = 16,
  parameter int ADDR_W      = 14,
  localparam int COL_W      = $clog2(GRID_COLS)
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire hfws_pkg::coef_t               coef_prev,
  input  wire hfws_pkg::coef_t               coef_center,
  input  wire hfws_pkg::coef_t               coef_neighbour,
  input  wire hfws_pkg::stn_beat_t           beat_i,
  input  wire logic [COL_W-1:0]              col_i,
  input  wire logic [ADDR_W-1:0]             waddr_i,
  input  wire logic signed [HEIGHT_BITS-1:0] cur_q,
  input  wire logic signed [HEIGHT_BITS-1:0] prv_q,
  output logic                               prv_we,
  output logic [ADDR_W-1:0]                  prv_waddr,
  output logic signed [HEIGHT_BITS-1:0]      prv_wdata,
  output logic                               busy
);

  import hfws_pkg::*;

  localparam int HB    = HEIGHT_BITS;
  localparam int NS_W  = HB + 2;
  localparam int PP_W  = HB + COEF_W;
  localparam int PN_W  = NS_W + COEF_W;
  localparam int ACC_W = HB + COEF_W + 4;
  localparam int SH_W  = ACC_W - FRAC_BITS;

  localparam logic signed [ACC_W-1:0] ROUND_C = ACC_W'(64'sd1 <<< (FRAC_BITS - 1));
  localparam logic signed [SH_W-1:0]  H_MAX   = SH_W'((64'sd1 <<< (HB - 1)) - 64'sd1);
  localparam logic signed [SH_W-1:0]  H_MIN   = SH_W'(-(64'sd1 <<< (HB - 1)));

  // stage 1: memory data back, window shift
  logic                     v1_r, int1_r;
  logic [COL_W-1:0]         c1_r;
  logic [ADDR_W-1:0]        wa1_r;
  logic signed [HB-1:0]     lb1_q, lb2_q;
  logic signed [HB-1:0]     mid_a_r, mid_b_r, top_a_r, bot_a_r;
  logic signed [NS_W-1:0]   nsum;

  // stage 2: operands
  logic                     v2_r;
  logic [ADDR_W-1:0]        wa2_r;
  logic signed [HB-1:0]     prv2_r, ctr2_r;
  logic signed [NS_W-1:0]   nsum2_r;

  // stage 3: products
  logic                     v3_r;
  logic [ADDR_W-1:0]        wa3_r;
  logic signed [PP_W-1:0]   pp3_r, pc3_r;
  logic signed [PN_W-1:0]   pn3_r;
  logic signed [ACC_W-1:0]  acc;
  logic signed [SH_W-1:0]   shv;

  // row delay lines: lb1 gives the row above the incoming one, lb2 two rows above
  hfws_ram #(.WIDTH(HB), .DEPTH(GRID_COLS)) u_lb1 (
    .clk   (clk),
    .we    (v1_r),
    .waddr (c1_r),
    .wdata (cur_q),
    .raddr (col_i),
    .rdata (lb1_q)
  );

  hfws_ram #(.WIDTH(HB), .DEPTH(GRID_COLS)) u_lb2 (
    .clk   (clk),
    .we    (v1_r),
    .waddr (c1_r),
    .wdata (lb1_q),
    .raddr (col_i),
    .rdata (lb2_q)
  );

  // window is centered one column behind the incoming beat
  assign nsum = NS_W'(mid_b_r) + NS_W'(lb1_q) + NS_W'(top_a_r) + NS_W'(bot_a_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      int1_r <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
    end else begin
      v1_r   <= beat_i.vld;
      int1_r <= beat_i.vld & beat_i.interior;
      v2_r   <= v1_r & int1_r;
      v3_r   <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    c1_r  <= col_i;
    wa1_r <= waddr_i;
    if (v1_r) begin
      mid_a_r <= lb1_q;
      mid_b_r <= mid_a_r;
      top_a_r <= lb2_q;
      bot_a_r <= cur_q;
    end
    wa2_r   <= wa1_r;
    prv2_r  <= prv_q;
    ctr2_r  <= mid_a_r;
    nsum2_r <= nsum;
    wa3_r   <= wa2_r;
    pp3_r   <= PP_W'(coef_prev) * PP_W'(prv2_r);
    pc3_r   <= PP_W'(coef_center) * PP_W'(ctr2_r);
    pn3_r   <= PN_W'(coef_neighbour) * PN_W'(nsum2_r);
  end

  // round half up, then clamp to the height range
  assign acc = ACC_W'(pp3_r) + ACC_W'(pc3_r) + ACC_W'(pn3_r) + ROUND_C;
  assign shv = SH_W'(acc >>> FRAC_BITS);

  always_comb begin
    if (shv > H_MAX) begin
      prv_wdata = HB'(H_MAX);
    end else if (shv < H_MIN) begin
      prv_wdata = HB'(H_MIN);
    end else begin
      prv_wdata = HB'(shv);
    end
  end

  assign prv_we    = v3_r;
  assign prv_waddr = wa3_r;
  assign busy      = v1_r | v2_r | v3_r;

endmodule

`default_nettype wire

[rtl/height_field_wave_step_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// channel | dir | handshake            | payload
// in_     | in  | in_tvalid/in_tready  | tuser req_type; tdata row, col, magnitude
// out_    | out | out_tvalid/out_tready| tuser status; tdata height
// cfg_    | in  | cfg_we               | cfg_index, cfg_data
//
// step: the raster sweep (one cell read per cycle from the current grid), the pipe
//   drain, the accept and the result load
// disturb, read and ignored requests each include the accept and the result load
//   into the output register
// after reset both grids are zeroed, one cell a cycle
// a waiting result holds the block in its done state until the beat is taken

module height_field_wave_step_unit #(
  parameter int GRID_ROWS   = 128,
  parameter int GRID_COLS   = 128,
  parameter int HEIGHT_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,    // cell_row[6:0], cell_col[13:7], magnitude[29:14]
  input  wire logic [1:0]  in_tuser,    // req_type[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,   // height[15:0]
  output logic             out_tuser,   // status[0]
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  import hfws_pkg::*;

  localparam int CELLS = GRID_ROWS * GRID_COLS;
  localparam int AW    = $clog2(CELLS);
  localparam int ROW_W = $clog2(GRID_ROWS);
  localparam int COL_W = $clog2(GRID_COLS);
  localparam int HB    = HEIGHT_BITS;

  localparam logic signed [32:0] H_MAX = 33'((64'sd1 <<< (HB - 1)) - 64'sd1);
  localparam logic signed [32:0] H_MIN = 33'(-(64'sd1 <<< (HB - 1)));

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_STEP  = 8'b0000_0100,
    S_FETCH = 8'b0000_1000,
    S_DCTR  = 8'b0001_0000,
    S_DNB   = 8'b0010_0000,
    S_RCAP  = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  coef_t coef_prev_r, coef_center_r, coef_neighbour_r;

  logic              cur_is_b_r;
  logic [AW-1:0]     clr_cnt_r;
  logic [AW-1:0]     sw_j_r;
  logic [ROW_W-1:0]  sw_row_r;
  logic [COL_W-1:0]  sw_col_r;
  logic              sw_done_r;
  logic              sw_last;
  logic [1:0]        nb_cnt_r;

  req_t                 req_r;
  logic [AW-1:0]        kaddr_r;
  logic signed [HB-1:0] mag_r;
  logic [15:0]          res_height_r;
  logic                 res_status_r;

  logic        out_tvalid_r;
  logic [15:0] out_tdata_r;
  logic        out_tuser_r;
  logic        out_free;

  // input beat fields
  req_t              in_req;
  logic [6:0]        in_row, in_col;
  logic signed [15:0] in_mag;
  logic              in_acc;
  logic              in_interior, in_inside;
  logic [AW-1:0]     in_kaddr;
  logic signed [32:0] mag_ext;
  logic signed [HB-1:0] mag_sat;

  // grid access
  logic                 clearing;
  logic [AW-1:0]        cur_raddr, prv_raddr, cur_waddr, nb_addr;
  logic                 cur_we;
  logic signed [HB-1:0] cur_wdata, cur_q, prv_q, half, ctr_new;
  logic signed [32:0]   ctr_sum;
  logic signed [31:0]   rd_ext;
  logic [HB-1:0]        a_q, b_q;
  logic                 a_we, b_we;
  logic [AW-1:0]        a_waddr, b_waddr, a_raddr, b_raddr;
  logic [HB-1:0]        a_wdata, b_wdata;

  // stencil pipe
  stn_beat_t            stn_beat;
  logic                 stn_we, stn_busy;
  logic [AW-1:0]        stn_waddr;
  logic signed [HB-1:0] stn_wdata;

  assign in_req = in_tuser;
  assign in_row = in_tdata[6:0];
  assign in_col = in_tdata[13:7];
  assign in_mag = in_tdata[29:14];

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid & in_tready;
  assign out_free  = !out_tvalid_r || out_tready;

  assign in_interior = (in_row >= 7'd1) && (32'(in_row) <= 32'(GRID_ROWS - 2)) &&
                       (in_col >= 7'd1) && (32'(in_col) <= 32'(GRID_COLS - 2));
  assign in_inside   = (32'(in_row) < 32'(GRID_ROWS)) && (32'(in_col) < 32'(GRID_COLS));
  assign in_kaddr    = AW'(32'(in_row) * 32'(GRID_COLS) + 32'(in_col));

  assign mag_ext = 33'(in_mag);
  always_comb begin
    if (mag_ext > H_MAX) begin
      mag_sat = HB'(H_MAX);
    end else if (mag_ext < H_MIN) begin
      mag_sat = HB'(H_MIN);
    end else begin
      mag_sat = HB'(mag_ext);
    end
  end

  // disturb values
  assign half    = mag_r >>> 1;
  assign ctr_sum = 33'(cur_q) + 33'(mag_r);
  always_comb begin
    if (ctr_sum > H_MAX) begin
      ctr_new = HB'(H_MAX);
    end else if (ctr_sum < H_MIN) begin
      ctr_new = HB'(H_MIN);
    end else begin
      ctr_new = HB'(ctr_sum);
    end
  end

  always_comb begin
    case (nb_cnt_r)
      2'd0:    nb_addr = kaddr_r - AW'(1);
      2'd1:    nb_addr = kaddr_r + AW'(1);
      2'd2:    nb_addr = kaddr_r - AW'(GRID_COLS);
      default: nb_addr = kaddr_r + AW'(GRID_COLS);
    endcase
  end

  assign rd_ext = 32'(cur_q);

  // sweep
  assign sw_last = (sw_j_r == AW'(CELLS - 1));
  assign stn_beat.vld      = (state_r == S_STEP) && !sw_done_r;
  assign stn_beat.interior = (sw_row_r >= ROW_W'(2)) && (sw_col_r >= COL_W'(2));

  // previous-grid cell that the window centers on when this beat's data is back
  assign prv_raddr = sw_j_r - AW'(GRID_COLS + 1);
  assign cur_raddr = (state_r == S_STEP) ? sw_j_r : kaddr_r;
  assign cur_we    = (state_r == S_DCTR) || (state_r == S_DNB);
  assign cur_waddr = (state_r == S_DCTR) ? kaddr_r : nb_addr;
  assign cur_wdata = (state_r == S_DCTR) ? ctr_new : half;
  assign clearing  = (state_r == S_CLEAR);

  // map current/previous roles onto the two grids
  always_comb begin
    if (cur_is_b_r) begin
      a_we    = stn_we;
      a_waddr = stn_waddr;
      a_wdata = stn_wdata;
      a_raddr = prv_raddr;
      b_we    = cur_we;
      b_waddr = cur_waddr;
      b_wdata = cur_wdata;
      b_raddr = cur_raddr;
      cur_q   = b_q;
      prv_q   = a_q;
    end else begin
      a_we    = cur_we;
      a_waddr = cur_waddr;
      a_wdata = cur_wdata;
      a_raddr = cur_raddr;
      b_we    = stn_we;
      b_waddr = stn_waddr;
      b_wdata = stn_wdata;
      b_raddr = prv_raddr;
      cur_q   = a_q;
      prv_q   = b_q;
    end
    if (clearing) begin
      a_we    = 1'b1;
      a_waddr = clr_cnt_r;
      a_wdata = '0;
      b_we    = 1'b1;
      b_waddr = clr_cnt_r;
      b_wdata = '0;
    end
  end

  hfws_ram #(.WIDTH(HB), .DEPTH(CELLS)) u_grid_a (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_waddr),
    .wdata (a_wdata),
    .raddr (a_raddr),
    .rdata (a_q)
  );

  hfws_ram #(.WIDTH(HB), .DEPTH(CELLS)) u_grid_b (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (b_wdata),
    .raddr (b_raddr),
    .rdata (b_q)
  );

  hfws_stencil #(
    .GRID_COLS   (GRID_COLS),
    .HEIGHT_BITS (HB),
    .ADDR_W      (AW)
  ) u_stencil (
    .clk            (clk),
    .rst_n          (rst_n),
    .coef_prev      (coef_prev_r),
    .coef_center    (coef_center_r),
    .coef_neighbour (coef_neighbour_r),
    .beat_i         (stn_beat),
    .col_i          (sw_col_r),
    .waddr_i        (prv_raddr),
    .cur_q          (cur_q),
    .prv_q          (prv_q),
    .prv_we         (stn_we),
    .prv_waddr      (stn_waddr),
    .prv_wdata      (stn_wdata),
    .busy           (stn_busy)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (clr_cnt_r == AW'(CELLS - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_req)
            REQ_STEP:    state_nxt = S_STEP;
            REQ_DISTURB: state_nxt = in_interior ? S_FETCH : S_DONE;
            REQ_READ:    state_nxt = in_inside ? S_FETCH : S_DONE;
            default:     state_nxt = S_DONE;
          endcase
        end
      end
      S_STEP: begin
        if (sw_done_r && !stn_busy) state_nxt = S_DONE;
      end
      S_FETCH: begin
        state_nxt = (req_r == REQ_DISTURB) ? S_DCTR : S_RCAP;
      end
      S_DCTR: begin
        state_nxt = S_DNB;
      end
      S_DNB: begin
        if (nb_cnt_r == 2'd3) state_nxt = S_DONE;
      end
      S_RCAP: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_CLEAR;
      clr_cnt_r        <= '0;
      cur_is_b_r       <= 1'b0;
      coef_prev_r      <= COEF_RESET;
      coef_center_r    <= COEF_RESET;
      coef_neighbour_r <= COEF_RESET;
      out_tvalid_r     <= 1'b0;
      sw_j_r           <= '0;
      sw_row_r         <= '0;
      sw_col_r         <= '0;
      sw_done_r        <= 1'b0;
      nb_cnt_r         <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_COEF_PREV:      coef_prev_r      <= cfg_data;
          REG_COEF_CENTER:    coef_center_r    <= cfg_data;
          REG_COEF_NEIGHBOUR: coef_neighbour_r <= cfg_data;
          default: ;
        endcase
      end
      if ((state_r == S_DONE) && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: clr_cnt_r <= clr_cnt_r + AW'(1);
        S_IDLE: begin
          if (in_acc) begin
            sw_j_r    <= '0;
            sw_row_r  <= '0;
            sw_col_r  <= '0;
            sw_done_r <= 1'b0;
          end
        end
        S_STEP: begin
          if (!sw_done_r) begin
            sw_j_r <= sw_j_r + AW'(1);
            if (sw_col_r == COL_W'(GRID_COLS - 1)) begin
              sw_col_r <= '0;
              sw_row_r <= sw_row_r + ROW_W'(1);
            end else begin
              sw_col_r <= sw_col_r + COL_W'(1);
            end
            if (sw_last) sw_done_r <= 1'b1;
          end else if (!stn_busy) begin
            cur_is_b_r <= !cur_is_b_r;
          end
        end
        S_DCTR: nb_cnt_r <= '0;
        S_DNB:  nb_cnt_r <= nb_cnt_r + 2'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r        <= in_req;
      kaddr_r      <= in_kaddr;
      mag_r        <= mag_sat;
      res_height_r <= '0;
      case (in_req)
        REQ_STEP:    res_status_r <= STATUS_DONE;
        REQ_DISTURB: res_status_r <= in_interior ? STATUS_DONE : STATUS_IGNORED;
        REQ_READ:    res_status_r <= in_inside ? STATUS_DONE : STATUS_IGNORED;
        default:     res_status_r <= STATUS_IGNORED;
      endcase
    end
    if (state_r == S_RCAP) res_height_r <= rd_ext[15:0];
    if ((state_r == S_DONE) && out_free) begin
      out_tdata_r <= res_height_r;
      out_tuser_r <= res_status_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // stencil pipe runs only inside a step
  a_stn_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_STEP) |-> !stn_busy)
    else $error("stencil pipe active outside a step");

  // grid roles swap only when a step finishes
  a_swap_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_is_b_r != $past(cur_is_b_r)) |-> ($past(state_r) == S_STEP))
    else $error("grid roles swapped outside a step");

  // a result beat is raised only from the done state
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> ($past(state_r) == S_DONE))
    else $error("result beat raised outside done state");

endmodule

`default_nettype wire
